[rtl/banded_edit_distance_assert.svh]
// Assertion macros shared by the banded edit distance RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef BANDED_EDIT_DISTANCE_ASSERT_SVH
`define BANDED_EDIT_DISTANCE_ASSERT_SVH
`ifndef SYNTHESIS
// expression holds at every edge out of reset
`define BED_ASSERT_HOLD(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("banded_edit_distance: invariant violated");
// consequent holds in the same cycle as the antecedent
`define BED_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("banded_edit_distance: implication violated");
// consequent holds in the cycle after the antecedent
`define BED_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("banded_edit_distance: next-cycle check violated");
`else
`define BED_ASSERT_HOLD(name, clk, rst, expr)
`define BED_ASSERT_SAME(name, clk, rst, ante, cons)
`define BED_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[rtl/bed_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the banded edit distance block.
// No dependencies; used by bed_ctrl, bed_datapath and the top level.
package bed_pkg;

   localparam int OP_W   = 2;
   localparam int SYM_W  = 8;
   localparam int LIM_W  = 7;
   localparam int DIST_W = 7;
   // band cells stay below 3*limit+2, so 9 bits hold them for any limit
   localparam int CELL_W = 9;

   localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

   // request opcodes
   localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

   // source of the reported distance
   typedef enum logic [1:0] {
      RES_MAX_LEN = 2'd0,
      RES_CUTOFF  = 2'd1,
      RES_CELL    = 2'd2
   } res_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        append_first;
      logic        append_second;
      logic        job_load;
      logic        init_begin;
      logic        init_step;
      logic        row_read;
      logic        row_capture;
      logic        cell_read;
      logic        cell_write;
      logic        row_end;
      logic        final_read;
      logic        res_valid;
      res_sel_type res_sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic n_zero;
      logic gap_over;
      logic init_last;
      logic cell_last;
      logic row_over;
      logic last_row;
      logic end_in_band;
   } status_type;

endpackage

[rtl/bed_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the banded edit distance block: request decode and band walk.
// Depends on bed_pkg and banded_edit_distance_assert.svh.
`include "banded_edit_distance_assert.svh"
module bed_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bed_pkg::OP_W-1:0]     req_op,
   input  bed_pkg::status_type          status,
   output bed_pkg::cmd_type             cmd,
   output logic                         busy
);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_CHECK   = 10'b00_0000_0010,
      S_INIT    = 10'b00_0000_0100,
      S_ROW_RD  = 10'b00_0000_1000,
      S_ROW_CAP = 10'b00_0001_0000,
      S_CELL_RD = 10'b00_0010_0000,
      S_CELL_WR = 10'b00_0100_0000,
      S_ROW_END = 10'b00_1000_0000,
      S_FIN_RD  = 10'b01_0000_0000,
      S_FIN_CAP = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_sel = bed_pkg::RES_CUTOFF;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_op)
                  bed_pkg::OP_APPEND_FIRST:  cmd.append_first  = 1'b1;
                  bed_pkg::OP_APPEND_SECOND: cmd.append_second = 1'b1;
                  bed_pkg::OP_COMPUTE: begin
                     cmd.job_load = 1'b1;
                     state_in     = S_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            priority if (status.n_zero) begin
               cmd.res_valid = 1'b1;
               cmd.res_sel   = bed_pkg::RES_MAX_LEN;
               state_in      = S_IDLE;
            end else if (status.gap_over) begin
               cmd.res_valid = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.init_begin = 1'b1;
               state_in       = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (status.init_last) state_in = S_ROW_RD;
         end
         S_ROW_RD: begin
            cmd.row_read = 1'b1;
            state_in     = S_ROW_CAP;
         end
         S_ROW_CAP: begin
            cmd.row_capture = 1'b1;
            state_in        = S_CELL_RD;
         end
         S_CELL_RD: begin
            cmd.cell_read = 1'b1;
            state_in      = S_CELL_WR;
         end
         S_CELL_WR: begin
            cmd.cell_write = 1'b1;
            state_in       = status.cell_last ? S_ROW_END : S_CELL_RD;
         end
         S_ROW_END: begin
            cmd.row_end = 1'b1;
            priority if (status.row_over) begin
               cmd.res_valid = 1'b1;
               state_in      = S_IDLE;
            end else if (status.last_row && !status.end_in_band) begin
               cmd.res_valid = 1'b1;
               state_in      = S_IDLE;
            end else if (status.last_row) begin
               state_in = S_FIN_RD;
            end else begin
               state_in = S_ROW_RD;
            end
         end
         S_FIN_RD: begin
            cmd.final_read = 1'b1;
            state_in       = S_FIN_CAP;
         end
         S_FIN_CAP: begin
            cmd.res_valid = 1'b1;
            cmd.res_sel   = bed_pkg::RES_CELL;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // every result ends the job
   `BED_ASSERT_NEXT(a_res_to_idle, clock, reset, cmd.res_valid, state_ff == S_IDLE)
   // a cell is written only right after its operands were read
   `BED_ASSERT_SAME(a_cell_after_read, clock, reset, state_ff == S_CELL_WR, $past(state_ff) == S_CELL_RD)
   // no request takes effect while a job runs
   `BED_ASSERT_SAME(a_no_req_busy, clock, reset, busy, !(cmd.append_first || cmd.append_second || cmd.job_load))

endmodule

[rtl/bed_datapath.sv]
`timescale 1ns / 1ps
// Datapath: string stores, two row buffers, band counters and cell update.
// Depends on bed_pkg and banded_edit_distance_assert.svh.
`include "banded_edit_distance_assert.svh"
module bed_datapath #(
   parameter int MAX_LEN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bed_pkg::SYM_W-1:0]     req_symbol,
   input  logic [bed_pkg::LIM_W-1:0]     req_limit,
   input  bed_pkg::cmd_type              cmd,
   output bed_pkg::status_type           status,
   output logic                          rsp_valid,
   output logic [bed_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_over_limit
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int XW    = ((LEN_W > bed_pkg::LIM_W) ? LEN_W : bed_pkg::LIM_W) + 1;
   localparam int DW    = (LEN_W > bed_pkg::CELL_W) ? LEN_W : bed_pkg::CELL_W;
   localparam int CW    = bed_pkg::CELL_W;
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_LEN);

   // storage
   logic [bed_pkg::SYM_W-1:0] first_mem  [MAX_LEN];
   logic [bed_pkg::SYM_W-1:0] second_mem [MAX_LEN];
   logic [CW-1:0]             row0_mem   [MAX_LEN + 1];
   logic [CW-1:0]             row1_mem   [MAX_LEN + 1];

   // control registers
   logic [LEN_W-1:0] first_len_ff, first_len_in;
   logic [LEN_W-1:0] second_len_ff, second_len_in;
   logic             rsp_valid_ff, rsp_valid_in;
   // job and band registers
   logic [bed_pkg::LIM_W-1:0] lim_ff, lim_in;
   logic             swap_ff, swap_in;
   logic             sel_ff, sel_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic [LEN_W-1:0] m_ff, m_in;
   logic [LEN_W-1:0] i_ff, i_in;
   logic [LEN_W-1:0] j_ff, j_in;
   logic [LEN_W-1:0] ps_ff, ps_in;
   logic [LEN_W-1:0] pe_ff, pe_in;
   logic [LEN_W-1:0] cst_ff, cst_in;
   logic [LEN_W-1:0] cen_ff, cen_in;
   logic [bed_pkg::SYM_W-1:0] rc_ff, rc_in;
   logic [CW-1:0]    diag_ff, diag_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [CW-1:0]    row_min_ff, row_min_in;
   logic [bed_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic             over_ff, over_in;
   // registered read data
   logic [bed_pkg::SYM_W-1:0] first_q_ff, second_q_ff;
   logic [CW-1:0]    row0_q_ff, row1_q_ff;

   // combinational helpers
   logic [XW-1:0]    lim_x, n_x, m_x, i_x, i_plus;
   logic [LEN_W-1:0] cst_c, cen_c, jm1, rb_addr;
   logic [AW-1:0]    str_addr;
   logic             str_rd_en, rb_rd_en, rb_wr_en, rb_wr_sel;
   logic [CW-1:0]    rb_wr_data, out_c, up_q, del_v, ins_v, sub_v, cell_v;
   logic [bed_pkg::SYM_W-1:0] cs_q;
   logic             del_ok, ins_ok, sub_ok;
   logic [DW-1:0]    d_c;

   assign lim_x  = XW'(lim_ff);
   assign n_x    = XW'(n_ff);
   assign m_x    = XW'(m_ff);
   assign i_x    = XW'(i_ff);
   assign i_plus = i_x + lim_x;
   assign out_c  = CW'(lim_ff) + CW'(1);

   // band limits of the row about to start
   assign cst_c = (i_x > lim_x) ? LEN_W'(i_x - lim_x) : '0;
   assign cen_c = (i_plus > m_x) ? m_ff : LEN_W'(i_plus);

   // read port addressing
   assign jm1       = j_ff - LEN_W'(1);
   assign str_rd_en = cmd.row_read | cmd.cell_read;
   assign rb_rd_en  = cmd.row_read | cmd.cell_read | cmd.final_read;
   always_comb begin
      priority if (cmd.row_read) begin
         str_addr = AW'(i_ff - LEN_W'(1));
         rb_addr  = (cst_c == '0) ? '0 : cst_c - LEN_W'(1);
      end else if (cmd.final_read) begin
         str_addr = '0;
         rb_addr  = m_ff;
      end else begin
         str_addr = (j_ff == '0) ? '0 : AW'(jm1);
         rb_addr  = j_ff;
      end
   end

   // operands; the shorter string indexes rows
   assign up_q = sel_ff ? row1_q_ff : row0_q_ff;
   assign cs_q = swap_ff ? first_q_ff : second_q_ff;

   // one band cell
   assign del_ok = (j_ff >= ps_ff) && (j_ff <= pe_ff);
   assign ins_ok = (j_ff > cst_ff);
   assign sub_ok = (j_ff != '0) && (jm1 >= ps_ff) && (jm1 <= pe_ff);
   assign del_v  = del_ok ? up_q + CW'(1) : out_c;
   assign ins_v  = ins_ok ? left_ff + CW'(1) : out_c;
   assign sub_v  = sub_ok ? diag_ff + CW'(rc_ff != cs_q) : out_c;
   always_comb begin
      cell_v = (del_v < ins_v) ? del_v : ins_v;
      if (sub_v < cell_v) cell_v = sub_v;
   end

   // row buffer write: init fills the upper row, cells fill the other one
   assign rb_wr_en   = cmd.init_step | cmd.cell_write;
   assign rb_wr_sel  = cmd.init_step ? sel_ff : ~sel_ff;
   assign rb_wr_data = cmd.init_step ? CW'(j_ff) : cell_v;

   // result value and saturation
   always_comb begin
      unique case (cmd.res_sel)
         bed_pkg::RES_MAX_LEN: d_c = DW'(m_ff);
         bed_pkg::RES_CUTOFF:  d_c = DW'(out_c);
         bed_pkg::RES_CELL:    d_c = DW'(up_q);
         default:              d_c = '0;
      endcase
   end

   // status to the controller
   assign status.n_zero      = (n_ff == '0);
   assign status.gap_over    = ((m_x - n_x) > lim_x);
   assign status.init_last   = (j_ff == pe_ff);
   assign status.cell_last   = (j_ff == cen_ff);
   assign status.row_over    = (row_min_ff > CW'(lim_ff));
   assign status.last_row    = (i_ff == n_ff);
   assign status.end_in_band = (m_ff >= cst_ff) && (m_ff <= cen_ff);

   // next values
   always_comb begin
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      lim_in     = lim_ff;
      swap_in    = swap_ff;
      sel_in     = sel_ff;
      n_in       = n_ff;
      m_in       = m_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      ps_in      = ps_ff;
      pe_in      = pe_ff;
      cst_in     = cst_ff;
      cen_in     = cen_ff;
      rc_in      = rc_ff;
      diag_in    = diag_ff;
      left_in    = left_ff;
      row_min_in = row_min_ff;
      rsp_valid_in = cmd.res_valid;
      dist_in    = dist_ff;
      over_in    = over_ff;

      if (cmd.append_first && (first_len_ff != LEN_FULL))
         first_len_in = first_len_ff + LEN_W'(1);
      if (cmd.append_second && (second_len_ff != LEN_FULL))
         second_len_in = second_len_ff + LEN_W'(1);

      // latch the job, order the strings, clear the lengths
      if (cmd.job_load) begin
         lim_in  = req_limit;
         swap_in = (first_len_ff > second_len_ff);
         n_in    = (first_len_ff > second_len_ff) ? second_len_ff : first_len_ff;
         m_in    = (first_len_ff > second_len_ff) ? first_len_ff : second_len_ff;
         first_len_in  = '0;
         second_len_in = '0;
      end

      if (cmd.init_begin) begin
         j_in  = '0;
         i_in  = LEN_W'(1);
         ps_in = '0;
         pe_in = (lim_x < m_x) ? LEN_W'(lim_ff) : m_ff;
      end
      if (cmd.init_step) j_in = j_ff + LEN_W'(1);

      if (cmd.row_read) begin
         cst_in     = cst_c;
         cen_in     = cen_c;
         j_in       = cst_c;
         row_min_in = out_c;
      end
      if (cmd.row_capture) begin
         rc_in   = swap_ff ? second_q_ff : first_q_ff;
         diag_in = up_q;
      end
      if (cmd.cell_write) begin
         left_in    = cell_v;
         diag_in    = up_q;
         row_min_in = (cell_v < row_min_ff) ? cell_v : row_min_ff;
         j_in       = j_ff + LEN_W'(1);
      end
      // swap row roles; this row becomes the upper one
      if (cmd.row_end) begin
         sel_in = ~sel_ff;
         ps_in  = cst_ff;
         pe_in  = cen_ff;
         i_in   = i_ff + LEN_W'(1);
      end

      if (cmd.res_valid) begin
         dist_in = (d_c > DW'(bed_pkg::DIST_MAX)) ? bed_pkg::DIST_MAX
                                                   : d_c[bed_pkg::DIST_W-1:0];
         over_in = (d_c > DW'(lim_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         sel_ff        <= 1'b0;
      end else begin
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         rsp_valid_ff  <= rsp_valid_in;
         sel_ff        <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff     <= lim_in;
      swap_ff    <= swap_in;
      n_ff       <= n_in;
      m_ff       <= m_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      ps_ff      <= ps_in;
      pe_ff      <= pe_in;
      cst_ff     <= cst_in;
      cen_ff     <= cen_in;
      rc_ff      <= rc_in;
      diag_ff    <= diag_in;
      left_ff    <= left_in;
      row_min_ff <= row_min_in;
      dist_ff    <= dist_in;
      over_ff    <= over_in;
   end

   // string stores
   always_ff @(posedge clock) begin
      if (cmd.append_first && (first_len_ff != LEN_FULL))
         first_mem[first_len_ff[AW-1:0]] <= req_symbol;
      if (str_rd_en) first_q_ff <= first_mem[str_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.append_second && (second_len_ff != LEN_FULL))
         second_mem[second_len_ff[AW-1:0]] <= req_symbol;
      if (str_rd_en) second_q_ff <= second_mem[str_addr];
   end

   // row buffers
   always_ff @(posedge clock) begin
      if (rb_wr_en && !rb_wr_sel) row0_mem[j_ff] <= rb_wr_data;
      if (rb_rd_en) row0_q_ff <= row0_mem[rb_addr];
   end

   always_ff @(posedge clock) begin
      if (rb_wr_en && rb_wr_sel) row1_mem[j_ff] <= rb_wr_data;
      if (rb_rd_en) row1_q_ff <= row1_mem[rb_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance   = dist_ff;
   assign rsp_over_limit = over_ff;

   // cells are written only inside the band of the current row
   `BED_ASSERT_SAME(a_cell_in_band, clock, reset, cmd.cell_write, (j_ff >= cst_ff) && (j_ff <= cen_ff))
   // initial row stays within its end column
   `BED_ASSERT_SAME(a_init_in_range, clock, reset, cmd.init_step, j_ff <= pe_ff)
   // a job clears the lengths and keeps the shorter string on rows
   `BED_ASSERT_NEXT(a_job_setup, clock, reset, cmd.job_load, (first_len_ff == '0) && (second_len_ff == '0) && (n_ff <= m_ff))

endmodule

[rtl/banded_edit_distance.sv]
`timescale 1ns / 1ps
// Top level of the banded edit distance block: controller plus datapath.
// Depends on bed_pkg, bed_ctrl and bed_datapath.
//
//   channel   ports                                        transfer when
//   request   start, busy, req_op, req_symbol, req_limit   start & !busy at clock edge
//   response  rsp_valid, rsp_distance, rsp_over_limit      rsp_valid, one cycle only
//
// Append requests leave busy low, so appends stream one per cycle.
// A compute request holds busy until its result; cols per row are at most 2*limit+1,
// and a band cell takes a read state and a write state for the registered row buffer
// read. Empty-string and length-gap exits return to idle straight from the check state.
// The result strobe comes in the cycle busy falls; a new request may transfer then.
// Reset is synchronous and clears lengths, sequencer and strobe; the receiver cannot stall.
module banded_edit_distance #(
   parameter int MAX_LEN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bed_pkg::OP_W-1:0]      req_op,
   input  logic [bed_pkg::SYM_W-1:0]     req_symbol,
   input  logic [bed_pkg::LIM_W-1:0]     req_limit,
   output logic                          rsp_valid,
   output logic [bed_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_over_limit
);

   bed_pkg::cmd_type    cmd;
   bed_pkg::status_type status;

   bed_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   bed_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_symbol     (req_symbol),
      .req_limit      (req_limit),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_distance   (rsp_distance),
      .rsp_over_limit (rsp_over_limit)
   );

endmodule
